FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the filter checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/cif_pkg.sv
// ---------------------------------------------------------------------------
// cif_pkg
// Types and constants shared by the complex IIR filter modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cif_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int ROUND_SHIFT = 14;
    localparam int MODE_W      = 2;
    localparam int INDEX_W     = 4;
    localparam int NUM_ORD_W   = 4;
    localparam int DEN_ORD_W   = 5;
    localparam int TAP_W       = 5;
    localparam int ITEM_W      = 72;
    localparam int RESULT_W    = 32;

    localparam logic [MODE_W-1:0] MODE_FILTER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NUM_WR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEN_WR = 2'd2;

    localparam logic REG_NUM_ORDER = 1'b0;
    localparam logic REG_DEN_ORDER = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NUM,
        S_DEN,
        S_DRAIN,
        S_ROUND,
        S_OUT
    } cif_state_t;

    typedef struct packed {
        logic             load_x;
        logic             num_wr;
        logic             den_wr;
        logic             issue;
        logic             issue_den;
        logic [TAP_W-1:0] tap;
        logic             round;
        logic             commit;
    } cif_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } cif_status_t;

endpackage

FILE: design/complex_iir_filter_unit.sv
// ---------------------------------------------------------------------------
// complex_iir_filter_unit
// Complex direct-form I IIR filter with stream ports and APB order registers.
// ---------------------------------------------------------------------------
// A filter word (tuser 0) takes one complex Q1.15 sample and returns one
// Q1.15 output word; coefficient words (tuser 1 and 2) load a Q2.14 tap and
// return nothing. One shared complex multiply-accumulate handles a tap per
// cycle, so a filter word occupies the block while it walks the numerator
// and feedback taps, drains the pipeline and rounds, plus any cycles spent
// waiting for the output register to free up. A new word is taken while the
// previous result still waits in the output register.
`timescale 1ns / 1ps

module complex_iir_filter_unit import cif_pkg::*; #(
    parameter int NUM_TAPS  = 16,
    parameter int DEN_TAPS  = 16,
    parameter int ACC_WIDTH = 40
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_tvalid,
    output logic                s_tready,
    // coef_index[3:0], coef_re[19:4], coef_im[35:20], sample_re[51:36],
    // sample_im[67:52], zero pad[71:68]
    input  logic [ITEM_W-1:0]   s_tdata,
    // mode[1:0]
    input  logic [MODE_W-1:0]   s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_re[15:0], out_im[31:16]
    output logic [RESULT_W-1:0] m_tdata
);

    logic [NUM_ORD_W-1:0]       num_order_reg;
    logic [DEN_ORD_W-1:0]       den_order_reg;
    logic                       cfg_wr;
    cif_cmd_t                   cmd;
    cif_status_t                status;
    logic signed [SAMPLE_W-1:0] out_re, out_im;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_order_reg <= '0;
            den_order_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_NUM_ORDER: num_order_reg <= pwdata[NUM_ORD_W-1:0];
                REG_DEN_ORDER: den_order_reg <= pwdata[DEN_ORD_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_NUM_ORDER: prdata = 32'(num_order_reg);
            REG_DEN_ORDER: prdata = 32'(den_order_reg);
            default:       prdata = '0;
        endcase
    end

    cif_ctrl #(
        .NUM_TAPS (NUM_TAPS),
        .DEN_TAPS (DEN_TAPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .mode      (s_tuser),
        .num_order (num_order_reg),
        .den_order (den_order_reg),
        .status    (status),
        .cmd       (cmd)
    );

    cif_datapath #(
        .NUM_TAPS  (NUM_TAPS),
        .DEN_TAPS  (DEN_TAPS),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .coef_index (s_tdata[3:0]),
        .coef_re    (s_tdata[19:4]),
        .coef_im    (s_tdata[35:20]),
        .sample_re  (s_tdata[51:36]),
        .sample_im  (s_tdata[67:52]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_re     (out_re),
        .out_im     (out_im)
    );

    assign m_tdata = {out_im, out_re};

endmodule

FILE: design/cif_ram.sv
// ---------------------------------------------------------------------------
// cif_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cif_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/cif_ctrl.sv
// ---------------------------------------------------------------------------
// cif_ctrl
// Sequencer: walks the numerator and feedback taps and commits each result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cif_ctrl import cif_pkg::*; #(
    parameter int NUM_TAPS = 16,
    parameter int DEN_TAPS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [MODE_W-1:0]    mode,
    input  logic [NUM_ORD_W-1:0] num_order,
    input  logic [DEN_ORD_W-1:0] den_order,
    input  cif_status_t          status,
    output cif_cmd_t             cmd
);

    cif_state_t       state_reg, state_next;
    logic [TAP_W-1:0] tap_reg, tap_next;
    logic [TAP_W-1:0] last_num;
    logic [TAP_W-1:0] den_cnt;

    assign last_num = (32'(num_order) > NUM_TAPS - 1) ? TAP_W'(NUM_TAPS - 1)
                                                       : TAP_W'(num_order);
    assign den_cnt  = (32'(den_order) > DEN_TAPS) ? TAP_W'(DEN_TAPS)
                                                   : TAP_W'(den_order);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        cmd        = '0;
        cmd.tap    = tap_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (mode)
                        MODE_FILTER:
                        begin
                            cmd.load_x = 1'b1;
                            tap_next   = '0;
                            state_next = S_NUM;
                        end
                        MODE_NUM_WR: cmd.num_wr = 1'b1;
                        MODE_DEN_WR: cmd.den_wr = 1'b1;
                        default:     ;
                    endcase
                end
            end
            S_NUM:
            begin
                cmd.issue = 1'b1;
                if (tap_reg == last_num)
                begin
                    tap_next   = '0;
                    state_next = (den_cnt == '0) ? S_DRAIN : S_DEN;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            S_DEN:
            begin
                cmd.issue     = 1'b1;
                cmd.issue_den = 1'b1;
                if (tap_reg == den_cnt - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

FILE: design/cif_datapath.sv
// ---------------------------------------------------------------------------
// cif_datapath
// Coefficient and history RAMs, shared complex MAC, rounding and output word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cif_datapath import cif_pkg::*; #(
    parameter int NUM_TAPS  = 16,
    parameter int DEN_TAPS  = 16,
    parameter int ACC_WIDTH = 40
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cif_cmd_t                   cmd,
    output cif_status_t                status,
    input  logic [INDEX_W-1:0]         coef_index,
    input  logic signed [COEF_W-1:0]   coef_re,
    input  logic signed [COEF_W-1:0]   coef_im,
    input  logic signed [SAMPLE_W-1:0] sample_re,
    input  logic signed [SAMPLE_W-1:0] sample_im,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_re,
    output logic signed [SAMPLE_W-1:0] out_im
);

    localparam int NA    = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam int DA    = (DEN_TAPS > 1) ? $clog2(DEN_TAPS) : 1;
    localparam int PW    = SAMPLE_W + COEF_W;
    localparam int EXT_W = (ACC_WIDTH > PW + 1) ? ACC_WIDTH : PW + 1;
    localparam int Q_W   = (ACC_WIDTH - ROUND_SHIFT + 1 > SAMPLE_W + 1)
                           ? ACC_WIDTH - ROUND_SHIFT + 1 : SAMPLE_W + 1;
    localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [Q_W-1:0] SAT_LO = Q_W'(-(2 ** (SAMPLE_W - 1)));
    localparam int CW    = 2 * COEF_W;
    localparam int HW    = 2 * SAMPLE_W;

    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [ACC_WIDTH-1:0] a
    );
        logic signed [Q_W-1:0] q;
        q = Q_W'(a >>> ROUND_SHIFT);
        if (a[ROUND_SHIFT-1])
        begin
            q = q + Q_W'(1);
        end
        if (q > SAT_HI)
        begin
            q = SAT_HI;
        end
        else if (q < SAT_LO)
        begin
            q = SAT_LO;
        end
        return SAMPLE_W'(q);
    endfunction

    // control and valid state
    logic [NUM_TAPS-1:0] num_cv_reg, xh_v_reg;
    logic [DEN_TAPS-1:0] den_cv_reg, yh_v_reg;
    logic [NA-1:0]       xh_head_reg, xh_head_next;
    logic [DA-1:0]       yh_head_reg, yh_head_next;
    logic                rd_v_reg, rd_den_reg, rd_x_reg, rd_cv_reg, rd_hv_reg;
    logic                prod_v_reg, prod_sub_reg;
    logic                out_valid_reg;

    // payload
    logic signed [SAMPLE_W-1:0]  x_re_reg, x_im_reg;
    logic signed [PW-1:0]        prod_rr_reg, prod_ii_reg, prod_ri_reg, prod_ir_reg;
    logic signed [ACC_WIDTH-1:0] acc_re_reg, acc_im_reg;
    logic signed [SAMPLE_W-1:0]  y_re_reg, y_im_reg;
    logic signed [SAMPLE_W-1:0]  out_re_reg, out_im_reg;

    logic                num_wr_en, den_wr_en;
    logic [NA-1:0]       num_addr, xh_rd_addr;
    logic [DA-1:0]       den_addr, yh_rd_addr;
    logic [NA:0]         xh_dist, xh_head_ext;
    logic [DA:0]         yh_dist, yh_head_ext;
    logic [CW-1:0]       num_q, den_q;
    logic [HW-1:0]       xh_q, yh_q;
    logic [CW-1:0]       coef_op;
    logic [HW-1:0]       hist_op;
    logic signed [SAMPLE_W-1:0] p_re, p_im;
    logic signed [COEF_W-1:0]   c_re, c_im;
    logic signed [EXT_W-1:0]    sum_re, sum_im;
    logic signed [ACC_WIDTH-1:0] term_re, term_im;

    assign num_wr_en = cmd.num_wr && (32'(coef_index) < NUM_TAPS);
    assign den_wr_en = cmd.den_wr && (32'(coef_index) < DEN_TAPS);
    assign num_addr  = cmd.issue_den ? NA'(coef_index) : NA'(cmd.tap);
    assign den_addr  = cmd.issue_den ? DA'(cmd.tap) : DA'(coef_index);

    // ring slot of x[n-k] is head-(k-1); of y[n-1-k] is head-k
    assign xh_head_ext = {1'b0, xh_head_reg};
    assign xh_dist     = (NA + 1)'(cmd.tap - 1'b1);
    assign xh_rd_addr  = (xh_head_ext >= xh_dist)
                         ? NA'(xh_head_ext - xh_dist)
                         : NA'(xh_head_ext + (NA + 1)'(NUM_TAPS) - xh_dist);
    assign yh_head_ext = {1'b0, yh_head_reg};
    assign yh_dist     = (DA + 1)'(cmd.tap);
    assign yh_rd_addr  = (yh_head_ext >= yh_dist)
                         ? DA'(yh_head_ext - yh_dist)
                         : DA'(yh_head_ext + (DA + 1)'(DEN_TAPS) - yh_dist);

    assign xh_head_next = (32'(xh_head_reg) == NUM_TAPS - 1) ? '0 : xh_head_reg + 1'b1;
    assign yh_head_next = (32'(yh_head_reg) == DEN_TAPS - 1) ? '0 : yh_head_reg + 1'b1;

    cif_ram #(.WIDTH(CW), .DEPTH(NUM_TAPS)) u_num_ram (
        .clk     (clk),
        .wr_en   (num_wr_en),
        .wr_addr (NA'(coef_index)),
        .wr_data ({coef_im, coef_re}),
        .rd_addr (num_addr),
        .rd_data (num_q)
    );

    cif_ram #(.WIDTH(CW), .DEPTH(DEN_TAPS)) u_den_ram (
        .clk     (clk),
        .wr_en   (den_wr_en),
        .wr_addr (DA'(coef_index)),
        .wr_data ({coef_im, coef_re}),
        .rd_addr (den_addr),
        .rd_data (den_q)
    );

    cif_ram #(.WIDTH(HW), .DEPTH(NUM_TAPS)) u_xh_ram (
        .clk     (clk),
        .wr_en   (cmd.commit),
        .wr_addr (xh_head_next),
        .wr_data ({x_im_reg, x_re_reg}),
        .rd_addr (xh_rd_addr),
        .rd_data (xh_q)
    );

    cif_ram #(.WIDTH(HW), .DEPTH(DEN_TAPS)) u_yh_ram (
        .clk     (clk),
        .wr_en   (cmd.commit),
        .wr_addr (yh_head_next),
        .wr_data ({y_im_reg, y_re_reg}),
        .rd_addr (yh_rd_addr),
        .rd_data (yh_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cv_reg    <= '0;
            den_cv_reg    <= '0;
            xh_v_reg      <= '0;
            yh_v_reg      <= '0;
            xh_head_reg   <= '0;
            yh_head_reg   <= '0;
            rd_v_reg      <= 1'b0;
            rd_den_reg    <= 1'b0;
            rd_x_reg      <= 1'b0;
            rd_cv_reg     <= 1'b0;
            rd_hv_reg     <= 1'b0;
            prod_v_reg    <= 1'b0;
            prod_sub_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (num_wr_en)
            begin
                num_cv_reg[NA'(coef_index)] <= 1'b1;
            end
            if (den_wr_en)
            begin
                den_cv_reg[DA'(coef_index)] <= 1'b1;
            end
            if (cmd.commit)
            begin
                xh_v_reg[xh_head_next] <= 1'b1;
                yh_v_reg[yh_head_next] <= 1'b1;
                xh_head_reg            <= xh_head_next;
                yh_head_reg            <= yh_head_next;
            end
            rd_v_reg   <= cmd.issue;
            rd_den_reg <= cmd.issue_den;
            rd_x_reg   <= !cmd.issue_den && (cmd.tap == '0);
            rd_cv_reg  <= cmd.issue_den ? den_cv_reg[den_addr] : num_cv_reg[num_addr];
            rd_hv_reg  <= cmd.issue_den ? yh_v_reg[yh_rd_addr] : xh_v_reg[xh_rd_addr];
            prod_v_reg   <= rd_v_reg;
            prod_sub_reg <= rd_den_reg;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // operand select: zero for never-written entries
    assign coef_op = !rd_cv_reg ? '0 : (rd_den_reg ? den_q : num_q);
    assign hist_op = rd_x_reg ? {x_im_reg, x_re_reg}
                   : (!rd_hv_reg ? '0 : (rd_den_reg ? yh_q : xh_q));
    assign c_re = coef_op[COEF_W-1:0];
    assign c_im = coef_op[CW-1:COEF_W];
    assign p_re = hist_op[SAMPLE_W-1:0];
    assign p_im = hist_op[HW-1:SAMPLE_W];

    assign sum_re  = EXT_W'(prod_rr_reg) - EXT_W'(prod_ii_reg);
    assign sum_im  = EXT_W'(prod_ri_reg) + EXT_W'(prod_ir_reg);
    assign term_re = ACC_WIDTH'(sum_re);
    assign term_im = ACC_WIDTH'(sum_im);

    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
        begin
            x_re_reg <= sample_re;
            x_im_reg <= sample_im;
        end
        prod_rr_reg <= p_re * c_re;
        prod_ii_reg <= p_im * c_im;
        prod_ri_reg <= p_re * c_im;
        prod_ir_reg <= p_im * c_re;
        if (cmd.load_x)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_re_reg <= prod_sub_reg ? acc_re_reg - term_re : acc_re_reg + term_re;
            acc_im_reg <= prod_sub_reg ? acc_im_reg - term_im : acc_im_reg + term_im;
        end
        if (cmd.round)
        begin
            y_re_reg <= round_sat(acc_re_reg);
            y_im_reg <= round_sat(acc_im_reg);
        end
        if (cmd.commit)
        begin
            out_re_reg <= y_re_reg;
            out_im_reg <= y_im_reg;
        end
    end

    assign status.pipe_busy = rd_v_reg || prod_v_reg;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_re           = out_re_reg;
    assign out_im           = out_im_reg;

endmodule

FILE: design/cif_checker.sv
// ---------------------------------------------------------------------------
// cif_checker
// Port-level checks for the complex IIR filter, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cif_checker import cif_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                psel,
    input logic                pready,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [MODE_W-1:0]   s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [RESULT_W-1:0] m_tdata
);

    logic s_word;

    assign s_word = s_tvalid && s_tready;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word dropped or changed while stalled")
    `ASSERT_NEXT(a_busy_after_filter, clk, rst_n, s_word && (s_tuser == MODE_FILTER), !s_tready, "input taken again during a filter run")
    `ASSERT_NEXT(a_coef_no_result, clk, rst_n, s_word && (s_tuser == MODE_NUM_WR || s_tuser == MODE_DEN_WR) && !m_tvalid, !m_tvalid, "coefficient word produced a result")
    `ASSERT_IMPLY(a_result_from_run, clk, rst_n, $rose(m_tvalid), $past(!s_tready), "result appeared outside a filter run")
    `ASSERT_IMPLY(a_pready_high, clk, rst_n, psel, pready, "config port stalled")

endmodule

bind complex_iir_filter_unit cif_checker u_cif_checker (.*);
